>>> rtl/pcps_pkg.sv
`default_nettype none

package pcps_pkg;

    // Field widths of the call and the response.
    localparam int FC_W   = 32;
    localparam int CORE_W = 8;
    localparam int ADDR_W = 64;
    localparam int CTX_W  = 64;
    localparam int RET_W  = 18;

    // Presence mask register and configuration port.
    localparam int MASK_BITS   = 8;
    localparam int MASK_IDX_W  = $clog2(MASK_BITS);
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_LSB = 2;
    localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_CORE_PRESENT = '0;
    localparam logic [MASK_BITS-1:0] CORE_PRESENT_RESET = 8'h01;

    // Design defaults.
    localparam int NUM_CORES_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Function identifiers.
    localparam logic [FC_W-1:0] FID_ARCH_MASK    = 32'hFFFF_0000;
    localparam logic [FC_W-1:0] FID_SMCCC_VER    = 32'h8000_0000;
    localparam logic [FC_W-1:0] FID_PSCI_MASK    = 32'hFFF0_0000;
    localparam logic [FC_W-1:0] FID_PSCI_VERSION = 32'h8400_0000;
    localparam logic [FC_W-1:0] FID_CPU_SUSPEND  = 32'h8400_0001;
    localparam logic [FC_W-1:0] FID_CPU_OFF      = 32'h8400_0002;
    localparam logic [FC_W-1:0] FID_CPU_ON       = 32'h8400_0003;
    localparam logic [FC_W-1:0] FID_AFFINITY     = 32'h8400_0004;
    localparam int              FID_CONV_BIT     = 30;

    typedef logic signed [RET_W-1:0] t_ret;

    localparam t_ret RET_SMCCC_VERSION = 18'sh10000;
    localparam t_ret RET_PSCI_VERSION  = 18'sd2;
    localparam t_ret RET_SUCCESS       = 18'sd0;
    localparam t_ret RET_AFF_ON        = 18'sd0;
    localparam t_ret RET_AFF_OFF       = 18'sd1;
    localparam t_ret RET_NOT_SUPPORTED = -18'sd1;
    localparam t_ret RET_INVALID_PARAM = -18'sd2;
    localparam t_ret RET_ALREADY_ON    = -18'sd3;
    localparam t_ret RET_NOT_PRESENT   = -18'sd6;

    typedef enum logic [1:0] {
        OP_RETURN,
        OP_CPU_ON,
        OP_AFFINITY
    } t_op;

    // Classified call as it travels from the front end to the executor.
    typedef struct packed {
        t_op                op;
        t_ret               ret;
        logic [CORE_W-1:0]  core;
        logic [ADDR_W-1:0]  addr;
        logic [CTX_W-1:0]   ctx;
    } t_cmd;

    typedef struct packed {
        t_ret               ret;
        logic               start;
        logic [CORE_W-1:0]  core;
        logic [ADDR_W-1:0]  addr;
        logic [CTX_W-1:0]   ctx;
    } t_resp;

endpackage

`default_nettype wire

>>> rtl/pcps_if.sv
`default_nettype none

interface pcps_call_if;
    logic                        valid;
    logic                        ready;
    logic [pcps_pkg::FC_W-1:0]   function_code;
    logic [pcps_pkg::CORE_W-1:0] target_core;
    logic [pcps_pkg::ADDR_W-1:0] entry_address;
    logic [pcps_pkg::CTX_W-1:0]  context_value;

    modport source (output valid, function_code, target_core, entry_address, context_value,
                    input ready);
    modport sink (input valid, function_code, target_core, entry_address, context_value,
                  output ready);
endinterface

interface pcps_resp_if;
    logic                        valid;
    logic                        ready;
    logic signed [pcps_pkg::RET_W-1:0] return_value;
    logic                        start_request;
    logic [pcps_pkg::CORE_W-1:0] start_core;
    logic [pcps_pkg::ADDR_W-1:0] start_address;
    logic [pcps_pkg::CTX_W-1:0]  start_context;

    modport source (output valid, return_value, start_request, start_core, start_address,
                    start_context, input ready);
    modport sink (input valid, return_value, start_request, start_core, start_address,
                  start_context, output ready);
endinterface

`default_nettype wire

>>> rtl/pcps_front.sv
`default_nettype none

module pcps_front (
    pcps_call_if.sink         i_call,
    input  wire logic         i_full,
    output logic              o_push,
    output pcps_pkg::t_cmd    o_cmd
);

    logic [pcps_pkg::FC_W-1:0] fc;
    logic [pcps_pkg::FC_W-1:0] base;

    assign i_call.ready = !i_full;
    assign o_push       = i_call.valid && !i_full;

    assign fc   = i_call.function_code;
    // The calling-convention bit is dropped so both forms decode alike.
    assign base = fc & ~(pcps_pkg::FC_W'(1) << pcps_pkg::FID_CONV_BIT);

    always_comb begin
        o_cmd.op   = pcps_pkg::OP_RETURN;
        o_cmd.ret  = pcps_pkg::RET_NOT_SUPPORTED;
        o_cmd.core = i_call.target_core;
        o_cmd.addr = i_call.entry_address;
        o_cmd.ctx  = i_call.context_value;
        if ((fc & pcps_pkg::FID_ARCH_MASK) == pcps_pkg::FID_SMCCC_VER) begin
            if (fc == pcps_pkg::FID_SMCCC_VER) begin
                o_cmd.ret = pcps_pkg::RET_SMCCC_VERSION;
            end
        end else if ((base & pcps_pkg::FID_PSCI_MASK) == pcps_pkg::FID_PSCI_VERSION) begin
            case (base)
                pcps_pkg::FID_PSCI_VERSION: o_cmd.ret = pcps_pkg::RET_PSCI_VERSION;
                pcps_pkg::FID_CPU_OFF:      o_cmd.ret = pcps_pkg::RET_SUCCESS;
                pcps_pkg::FID_CPU_ON:       o_cmd.op  = pcps_pkg::OP_CPU_ON;
                pcps_pkg::FID_AFFINITY:     o_cmd.op  = pcps_pkg::OP_AFFINITY;
                default:                    o_cmd.ret = pcps_pkg::RET_NOT_SUPPORTED;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcps_queue.sv
`default_nettype none

module pcps_queue #(
    parameter int DEPTH = pcps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  pcps_pkg::t_cmd      i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output pcps_pkg::t_cmd      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcps_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcps_back.sv
`default_nettype none

module pcps_back #(
    parameter int NUM_CORES = pcps_pkg::NUM_CORES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [pcps_pkg::MASK_BITS-1:0] i_present_mask,
    input  wire logic                           i_valid,
    input  pcps_pkg::t_cmd                      i_head,
    output logic                                o_pop,
    pcps_resp_if.source                         o_resp
);

    localparam int IDX_W = $clog2(NUM_CORES);
    localparam logic [pcps_pkg::CORE_W-1:0] CORE_LIMIT = pcps_pkg::CORE_W'(NUM_CORES);
    localparam logic [pcps_pkg::CORE_W-1:0] MASK_LIMIT = pcps_pkg::CORE_W'(pcps_pkg::MASK_BITS);

    logic [NUM_CORES-1:0]        r_running;
    logic                        r_out_valid;
    pcps_pkg::t_resp             r_out, n_out;
    logic [pcps_pkg::CORE_W-1:0] id;
    logic [IDX_W-1:0]            idx;
    logic                        in_range;
    logic                        is_boot;
    logic                        present;
    logic                        running;

    assign o_pop = i_valid && (!r_out_valid || o_resp.ready);

    assign id       = i_head.core;
    assign idx      = id[IDX_W-1:0];
    assign in_range = (id < CORE_LIMIT);
    assign is_boot  = (id == '0);
    // Cores beyond the width of the mask are never present.
    assign present  = (id < MASK_LIMIT) && i_present_mask[id[pcps_pkg::MASK_IDX_W-1:0]];
    assign running  = in_range && r_running[idx];

    always_comb begin
        n_out       = '0;
        n_out.ret   = i_head.ret;
        case (i_head.op)
            pcps_pkg::OP_RETURN: begin
                n_out.ret = i_head.ret;
            end
            pcps_pkg::OP_CPU_ON: begin
                if (!in_range || is_boot || !present) begin
                    n_out.ret = pcps_pkg::RET_INVALID_PARAM;
                end else if (running) begin
                    n_out.ret = pcps_pkg::RET_ALREADY_ON;
                end else begin
                    n_out.ret   = pcps_pkg::RET_SUCCESS;
                    n_out.start = 1'b1;
                    n_out.core  = id;
                    n_out.addr  = i_head.addr;
                    n_out.ctx   = i_head.ctx;
                end
            end
            pcps_pkg::OP_AFFINITY: begin
                if (!in_range) begin
                    n_out.ret = pcps_pkg::RET_INVALID_PARAM;
                end else if (is_boot) begin
                    n_out.ret = pcps_pkg::RET_AFF_ON;
                end else if (!present) begin
                    n_out.ret = pcps_pkg::RET_NOT_PRESENT;
                end else begin
                    n_out.ret = running ? pcps_pkg::RET_AFF_ON : pcps_pkg::RET_AFF_OFF;
                end
            end
            default: begin
                n_out.ret = pcps_pkg::RET_NOT_SUPPORTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_resp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && n_out.start) begin
                r_running[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_resp.valid         = r_out_valid;
    assign o_resp.return_value  = r_out.ret;
    assign o_resp.start_request = r_out.start;
    assign o_resp.start_core    = r_out.core;
    assign o_resp.start_address = r_out.addr;
    assign o_resp.start_context = r_out.ctx;

    a_start_is_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.start |-> r_out.ret == pcps_pkg::RET_SUCCESS)
        else $error("start request without a success code");

    a_start_core_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.start |-> r_out.core != '0 && r_out.core < CORE_LIMIT)
        else $error("start request names the boot core or a missing core");

    a_start_marks_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && n_out.start |=> r_running[$past(idx)])
        else $error("started core not marked running");

    a_no_start_when_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.op == pcps_pkg::OP_CPU_ON && running |-> !n_out.start)
        else $error("running core started again");

endmodule

`default_nettype wire

>>> rtl/psci_call_power_state_handler_core.sv
// Power-state call handler. Each call item (function identifier, target core,
// entry address, context) yields exactly one response item: SMCCC version and
// PSCI VERSION, CPU_OFF, CPU_ON and AFFINITY_INFO are answered, everything else
// returns not-supported. A successful CPU_ON marks the core running and raises
// start_request with the core, entry address and context; all start fields are
// zero otherwise. The front end decodes a call in the cycle it is accepted and
// writes it into a queue (QUEUE_DEPTH entries, two by default); the executor
// takes one queued call per cycle while its response register is free or
// being taken, reads and updates the per-core running bits and registers
// the response, so the block sustains one item per cycle unless the response
// side stalls, while the queue keeps accepting calls until it is full. The
// core presence mask sits at byte address 0 of the APB port (reset value 1);
// the user must change it only while the block is idle; it is not enforced.
`default_nettype none

module psci_call_power_state_handler_core #(
    parameter int NUM_CORES   = pcps_pkg::NUM_CORES_DEF,
    parameter int QUEUE_DEPTH = pcps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    pcps_call_if.sink                             i_call,
    pcps_resp_if.source                           o_resp,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pcps_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [pcps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [pcps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    logic [pcps_pkg::MASK_BITS-1:0] r_present_mask;
    logic                           reg_hit;
    logic                           q_full;
    logic                           q_push;
    logic                           q_pop;
    logic                           q_valid;
    pcps_pkg::t_cmd                 q_in;
    pcps_pkg::t_cmd                 q_head;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[pcps_pkg::APB_ADDR_W-1:pcps_pkg::REG_IDX_LSB]
                      == pcps_pkg::REG_CORE_PRESENT);
    assign prdata  = reg_hit ? pcps_pkg::APB_DATA_W'(r_present_mask) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present_mask <= pcps_pkg::CORE_PRESENT_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_present_mask <= pwdata[pcps_pkg::MASK_BITS-1:0];
        end
    end

    pcps_front u_front (
        .i_call (i_call),
        .i_full (q_full),
        .o_push (q_push),
        .o_cmd  (q_in)
    );

    pcps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    pcps_back #(
        .NUM_CORES (NUM_CORES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_present_mask (r_present_mask),
        .i_valid        (q_valid),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_resp         (o_resp)
    );

endmodule

`default_nettype wire
